@@ design/olb_pkg.sv @@
// Shared constants, bin record layout and controller/datapath interface types.
package olb_pkg;

    localparam int unsigned MAX_BINS_DEF = 16;

    localparam int SAMPLE_W = 32;
    localparam int INDEX_W  = 4;
    localparam int MEAN_W   = 32;
    localparam int SUM_W    = 64;
    localparam int HITS_W   = 32;

    // restoring divider: one quotient bit per step, quotient fits in HITS_W bits
    localparam int DIV_STEPS = HITS_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic        [HITS_W-1:0]   hits;
        logic signed [SUM_W-1:0]    sum;
        logic signed [MEAN_W-1:0]   avg;
        logic signed [SAMPLE_W-1:0] high;
        logic signed [SAMPLE_W-1:0] low;
    } bin_entry_t;

    localparam int ENTRY_W = $bits(bin_entry_t);

    typedef struct packed {
        logic take;      // latch request sample, restart scan
        logic rd;        // read bin at scan index
        logic test;      // evaluate read bin, latch joined values
        logic div_init;  // load divider
        logic div_step;  // one divider step
        logic wr_join;   // write joined bin, load result
        logic wr_new;    // start new bin, load result
        logic set_full;  // load table-full result
    } dp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic table_full;
        logic match;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ design/olb_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module olb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/olb_datapath.sv @@
// Bin store, match test, saturating update, serial mean divider and result register.
module olb_datapath #(
    parameter int unsigned MAX_BINS = olb_pkg::MAX_BINS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  olb_pkg::dp_cmd_t                    cmd,
    output olb_pkg::dp_status_t                 status,
    input  logic signed [olb_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [olb_pkg::INDEX_W-1:0]         m_bin_index,
    output logic                                m_created,
    output logic                                m_table_full,
    output logic signed [olb_pkg::MEAN_W-1:0]   m_bin_mean_out
);
    import olb_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int UW = $clog2(MAX_BINS + 1);
    localparam logic [UW-1:0] MAX_CNT = UW'(MAX_BINS);

    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [UW-1:0]              idx_reg, idx_next;
    logic [UW-1:0]              used_reg, used_next;
    bin_entry_t                 ent_reg;
    logic                       neg_reg, ovf_reg;
    logic [HITS_W-1:0]          rem_reg, rem_next;
    logic [HITS_W-1:0]          dq_reg, dq_next;
    logic [DCNT_W-1:0]          cnt_reg, cnt_next;

    logic                       m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]         m_index_reg;
    logic                       m_created_reg, m_full_reg;
    logic signed [MEAN_W-1:0]   m_mean_reg;

    logic [ENTRY_W-1:0]         ram_rd_data, ram_wr_data;
    bin_entry_t                 ram_q, join_ent, new_ent;

    logic                       in_range, in_window, match;
    logic signed [SAMPLE_W+2:0] four_s, m1, m3, m5;

    logic [HITS_W-1:0]          hits_inc;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;

    logic [SUM_W-1:0]           sum_mag;
    logic [HITS_W:0]            div_shift;
    logic                       div_ge;
    logic signed [MEAN_W-1:0]   mean;

    logic                       out_free;

    // ---- bin store
    assign ram_q = bin_entry_t'(ram_rd_data);

    olb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (cmd.wr_join | cmd.wr_new),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // ---- match test on the bin just read
    always_comb begin
        four_s    = {sample_reg[SAMPLE_W-1], sample_reg, 2'b00};
        m1        = {{3{ram_q.avg[MEAN_W-1]}}, ram_q.avg};
        m3        = m1 + (m1 <<< 1);
        m5        = m1 + (m1 <<< 2);
        in_range  = (sample_reg >= ram_q.low) && (sample_reg <= ram_q.high);
        in_window = (four_s >= m3) && (four_s <= m5);
        match     = in_range || in_window;
    end

    // ---- saturating join update
    always_comb begin
        hits_inc = (&ram_q.hits) ? ram_q.hits : ram_q.hits + HITS_W'(1);
        sum_wide = {ram_q.sum[SUM_W-1], ram_q.sum}
                 + {{(SUM_W-SAMPLE_W+1){sample_reg[SAMPLE_W-1]}}, sample_reg};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // ---- divider: magnitude of sum over hits, high half checked for overflow up front
    always_comb begin
        sum_mag   = ent_reg.sum[SUM_W-1] ? 64'(-ent_reg.sum) : ent_reg.sum;
        div_shift = {rem_reg, dq_reg[HITS_W-1]};
        div_ge    = div_shift >= {1'b0, ent_reg.hits};
        if (cmd.div_init) begin
            rem_next = sum_mag[SUM_W-1:HITS_W];
            dq_next  = sum_mag[HITS_W-1:0];
            cnt_next = DCNT_W'(DIV_STEPS - 1);
        end else if (cmd.div_step) begin
            rem_next = div_ge ? HITS_W'(div_shift - {1'b0, ent_reg.hits})
                              : div_shift[HITS_W-1:0];
            dq_next  = {dq_reg[HITS_W-2:0], div_ge};
            // step counter rests at zero once the last step is done
            cnt_next = (cnt_reg == '0) ? cnt_reg : cnt_reg - DCNT_W'(1);
        end else begin
            rem_next = rem_reg;
            dq_next  = dq_reg;
            cnt_next = cnt_reg;
        end
    end

    always_comb begin
        if (ovf_reg || dq_reg[HITS_W-1]) begin
            mean = neg_reg ? MEAN_MIN : MEAN_MAX;
        end else begin
            mean = neg_reg ? MEAN_W'(-dq_reg) : MEAN_W'(dq_reg);
        end
    end

    // ---- write data
    always_comb begin
        join_ent     = ent_reg;
        join_ent.avg = mean;
        new_ent.low  = sample_reg;
        new_ent.high = sample_reg;
        new_ent.avg  = sample_reg;
        new_ent.sum  = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        new_ent.hits = HITS_W'(1);
        ram_wr_data  = cmd.wr_new ? new_ent : join_ent;
    end

    // ---- counters
    always_comb begin
        idx_next  = idx_reg;
        used_next = used_reg;
        if (cmd.take) begin
            idx_next = '0;
        end else if (cmd.test && !match) begin
            idx_next = idx_reg + UW'(1);
        end
        if (cmd.wr_new) begin
            used_next = used_reg + UW'(1);
        end
    end

    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = (cmd.wr_join || cmd.wr_new || cmd.set_full) ? 1'b1
                        : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            used_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            used_reg    <= used_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sample_reg <= s_sample;
        end
        if (cmd.test) begin
            ent_reg.low  <= (sample_reg < ram_q.low)  ? sample_reg : ram_q.low;
            ent_reg.high <= (sample_reg > ram_q.high) ? sample_reg : ram_q.high;
            ent_reg.avg  <= ram_q.avg;
            ent_reg.sum  <= sum_sat;
            ent_reg.hits <= hits_inc;
        end
        if (cmd.div_init) begin
            neg_reg <= ent_reg.sum[SUM_W-1];
            ovf_reg <= sum_mag[SUM_W-1:HITS_W] >= ent_reg.hits;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (cmd.wr_join) begin
            m_index_reg   <= INDEX_W'(idx_reg);
            m_created_reg <= 1'b0;
            m_full_reg    <= 1'b0;
            m_mean_reg    <= mean;
        end else if (cmd.wr_new) begin
            m_index_reg   <= INDEX_W'(idx_reg);
            m_created_reg <= 1'b1;
            m_full_reg    <= 1'b0;
            m_mean_reg    <= sample_reg;
        end else if (cmd.set_full) begin
            m_index_reg   <= '0;
            m_created_reg <= 1'b0;
            m_full_reg    <= 1'b1;
            m_mean_reg    <= '0;
        end
    end

    assign status.scan_end   = (idx_reg == used_reg);
    assign status.table_full = (used_reg == MAX_CNT);
    assign status.match      = match;
    assign status.div_last   = (cnt_reg == '0);
    assign status.out_free   = out_free;

    assign m_valid        = m_valid_reg;
    assign m_bin_index    = m_index_reg;
    assign m_created      = m_created_reg;
    assign m_table_full   = m_full_reg;
    assign m_bin_mean_out = m_mean_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= MAX_CNT)
        else $error("bin count beyond table size");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= used_reg)
        else $error("scan index past bins in use");

    a_new_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_new |-> (used_reg < MAX_CNT) && (idx_reg == used_reg))
        else $error("new bin started without a free slot");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_join |-> (cnt_reg == '0))
        else $error("join written before divider finished");

endmodule

@@ design/olb_ctrl.sv @@
// Sequencer: bin scan, join with mean division, new bin or table-full outcome.
module olb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olb_pkg::dp_status_t status,
    output olb_pkg::dp_cmd_t    cmd
);
    import olb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RD    = 8'b0000_0010,
        ST_TEST  = 8'b0000_0100,
        ST_DINIT = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_JOIN  = 8'b0010_0000,
        ST_NEW   = 8'b0100_0000,
        ST_FULL  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                if (status.scan_end) begin
                    state_next = status.table_full ? ST_FULL : ST_NEW;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                cmd.test   = 1'b1;
                state_next = status.match ? ST_DINIT : ST_RD;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_JOIN;
                end
            end
            ST_JOIN: begin
                if (status.out_free) begin
                    cmd.wr_join = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_NEW: begin
                if (status.out_free) begin
                    cmd.wr_new = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FULL: begin
                if (status.out_free) begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    a_take_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RD))
        else $error("accepted request did not start a scan");

endmodule

@@ design/online_leader_binning.sv @@
// Top level of the online leader binning block.
// Each request is a signed Q16.16 sample; exactly one result is returned per
// request. Bins are probed in index order, one bin memory read per probe, in a
// read state then a test state. A sample joining a bin passes divider init and
// the 32-step restoring divider for the new mean before its result is written;
// a sample that starts a new bin, or finds the table full, is answered once the
// scan has passed all bins in use. One request is worked on at a time; the next
// is accepted as soon as the result is in the output register, even if it has
// not yet been taken. Bin storage needs no clearing after reset.
module online_leader_binning #(
    parameter int unsigned MAX_BINS = olb_pkg::MAX_BINS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [olb_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [olb_pkg::INDEX_W-1:0]         m_bin_index,
    output logic                                m_created,
    output logic                                m_table_full,
    output logic signed [olb_pkg::MEAN_W-1:0]   m_bin_mean_out
);
    import olb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    olb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    olb_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_sample       (s_sample),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_bin_index    (m_bin_index),
        .m_created      (m_created),
        .m_table_full   (m_table_full),
        .m_bin_mean_out (m_bin_mean_out)
    );

endmodule
